// ===== hw/rtl/mvtb_pkg.sv =====
// Shared types and constants for the mesh vertex transform batcher.
// No dependencies; imported by mesh_vertex_transform_batcher_top.
`timescale 1ns / 1ps

package mvtb_pkg;

    // Input transaction modes
    localparam logic [2:0] MODE_ROW    = 3'd0;
    localparam logic [2:0] MODE_BEGIN  = 3'd1;
    localparam logic [2:0] MODE_VERTEX = 3'd2;
    localparam logic [2:0] MODE_INDEX  = 3'd3;
    localparam logic [2:0] MODE_FRAME  = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_INDEX  = 2'd1;
    localparam logic [1:0] KIND_BATCH  = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_INDEX = 2'd1;
    localparam logic [1:0] ERR_WZERO = 2'd2;
    localparam logic [1:0] ERR_FULL  = 2'd3;

    // Largest vertex span of one batch (16-bit indices)
    localparam logic [16:0] BATCH_LIMIT = 17'd65535;

    // 1.0 in Q16.16, the implicit w coordinate of every vertex
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    // Width of a row dot product: three floored Q32.32 products plus a coefficient
    localparam int ACC_W = 50;

    // Saturation limits of a Q16.16 quotient
    localparam logic [31:0] Q_MAX_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MAX_NEG = 32'h8000_0000;

endpackage

// ===== hw/rtl/mesh_vertex_transform_batcher_top.sv =====
// Mesh vertex transform batcher: matrix load, vertex transform with divide, batching.
// Depends on mvtb_pkg.
`timescale 1ns / 1ps

// Takes one transaction at a time. A row load or start-frame transaction completes
// on acceptance; a begin-mesh or index transaction is accepted, then written to the result
// register. A vertex passes through the single 32x32 multiplier for the sixteen matrix
// terms, then three divisions (setup, 32 restoring steps of one quotient bit,
// saturation) on the shared divider, then writes the result; a vertex whose w is zero
// skips the divisions. The result register decouples the output: the next transaction is
// accepted while a result still waits behind out_stall.
module mesh_vertex_transform_batcher_top
    import mvtb_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1048576
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         mode,
    input  logic [1:0]         row,
    input  logic signed [31:0] coef_a,
    input  logic signed [31:0] coef_b,
    input  logic signed [31:0] coef_c,
    input  logic signed [31:0] coef_d,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [15:0]        vertex_index,
    input  logic [15:0]        mesh_vertex_count,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic [15:0]        out_index,
    output logic               new_batch,
    output logic [20:0]        batch_first,
    output logic [20:0]        batch_base,
    output logic [20:0]        closed_count,
    output logic [1:0]         error
);

    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ELEMENTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_SET,
        ST_DIV_RUN,
        ST_DIV_END,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // Captured transaction
    logic [2:0]         mode_reg;
    logic signed [31:0] pos_reg [3];
    logic [15:0]        vidx_reg;
    logic [15:0]        mvc_reg;

    // Matrix and batching state
    logic [31:0]   matrix_reg [16];
    logic [CW-1:0] vtotal_reg;
    logic [CW-1:0] itotal_reg;
    logic [CW-1:0] cfirst_reg;
    logic [CW-1:0] cbase_reg;
    logic [CW-1:0] bic_reg;
    logic [15:0]   moffset_reg;
    logic [15:0]   mverts_reg;
    logic          bopen_reg;

    // Multiply-accumulate datapath
    logic [4:0]              step_reg;
    logic signed [63:0]      prod_reg;
    logic [1:0]              prow_reg;
    logic                    plast_reg;
    logic                    pvld_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] dot_reg [4];

    // Divider datapath
    logic [1:0]       dsel_reg;
    logic [ACC_W-1:0] uw_reg;
    logic [ACC_W-1:0] rem_reg;
    logic [31:0]      dvd_reg;
    logic [31:0]      q_reg;
    logic [4:0]       cnt_reg;
    logic             neg_reg;
    logic             ovf_reg;
    logic [31:0]      res_reg [3];

    // Output register
    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [31:0] ox_reg, oy_reg, oz_reg;
    logic [15:0] oidx_reg;
    logic        nb_reg;
    logic [20:0] bfirst_reg, bbase_reg, closed_reg;
    logic [1:0]  err_reg;

    // Shared multiplier operands
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_next;
    logic signed [ACC_W-1:0] term, sum_next;

    always_comb
    begin
        mul_a = $signed(matrix_reg[step_reg[3:0]]);
        case (step_reg[1:0])
            2'd0:    mul_b = pos_reg[0];
            2'd1:    mul_b = pos_reg[1];
            2'd2:    mul_b = pos_reg[2];
            default: mul_b = $signed(ONE_Q16);
        endcase
        prod_next = mul_a * mul_b;
        // floor to Q16.16 is an arithmetic shift
        term     = {{(ACC_W - 48){prod_reg[63]}}, prod_reg[63:16]};
        sum_next = acc_reg + term;
    end

    // Divider setup values and one restoring step
    logic signed [ACC_W-1:0] dnum;
    logic [ACC_W-1:0] ua_next, uw_next;
    logic [ACC_W:0]   trial;
    logic             ge;
    logic [31:0]      sat_next;

    always_comb
    begin
        dnum    = dot_reg[dsel_reg];
        ua_next = dnum[ACC_W-1] ? ACC_W'(-dnum) : ACC_W'(dnum);
        uw_next = dot_reg[3][ACC_W-1] ? ACC_W'(-dot_reg[3]) : ACC_W'(dot_reg[3]);
        trial   = {rem_reg, dvd_reg[31]};
        ge      = trial >= {1'b0, uw_reg};
        if (ovf_reg)
            sat_next = neg_reg ? Q_MAX_NEG : Q_MAX_POS;
        else if (!neg_reg)
            sat_next = (q_reg > Q_MAX_POS) ? Q_MAX_POS : q_reg;
        else
            sat_next = (q_reg > Q_MAX_NEG) ? Q_MAX_NEG : 32'(-q_reg);
    end

    // Batch decisions for a begin-mesh transaction
    logic [CW:0]   vsum_next, span_next;
    logic          toobig, open_new;
    logic [CW-1:0] base_next;

    always_comb
    begin
        vsum_next = {1'b0, vtotal_reg} + (CW+1)'(mvc_reg);
        span_next = {1'b0, vtotal_reg - cbase_reg} + (CW+1)'(mvc_reg);
        toobig    = vsum_next > (CW+1)'(MAX_ELEMENTS);
        open_new  = !bopen_reg || (span_next > (CW+1)'(BATCH_LIMIT));
        base_next = open_new ? vtotal_reg : cbase_reg;
    end

    logic wzero, emit_go, emit_fire, in_fire, out_fire;

    assign wzero     = (dot_reg[3] == '0);
    assign emit_go   = !out_valid_reg || !out_stall;
    assign emit_fire = (state_reg == ST_EMIT) && emit_go;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;

    // Sequencer, datapath and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= '0;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                res_reg[i] <= '0;
            end
            for (int i = 0; i < 16; i++)
                matrix_reg[i] <= '0;
            for (int i = 0; i < 4; i++)
                dot_reg[i] <= '0;
            vidx_reg      <= '0;
            mvc_reg       <= '0;
            vtotal_reg    <= '0;
            itotal_reg    <= '0;
            cfirst_reg    <= '0;
            cbase_reg     <= '0;
            bic_reg       <= '0;
            moffset_reg   <= '0;
            mverts_reg    <= '0;
            bopen_reg     <= 1'b0;
            step_reg      <= '0;
            prod_reg      <= '0;
            prow_reg      <= '0;
            plast_reg     <= 1'b0;
            pvld_reg      <= 1'b0;
            acc_reg       <= '0;
            dsel_reg      <= '0;
            uw_reg        <= '0;
            rem_reg       <= '0;
            dvd_reg       <= '0;
            q_reg         <= '0;
            cnt_reg       <= '0;
            neg_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg      <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            oz_reg        <= '0;
            oidx_reg      <= '0;
            nb_reg        <= 1'b0;
            bfirst_reg    <= '0;
            bbase_reg     <= '0;
            closed_reg    <= '0;
            err_reg       <= '0;
        end
        else
        begin
            // drained result; a new one written this cycle takes its place
            if (out_fire && !emit_fire)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        mode_reg   <= mode;
                        pos_reg[0] <= pos_x;
                        pos_reg[1] <= pos_y;
                        pos_reg[2] <= pos_z;
                        vidx_reg   <= vertex_index;
                        mvc_reg    <= mesh_vertex_count;
                        case (mode) inside
                            MODE_ROW:
                            begin
                                matrix_reg[{row, 2'd0}] <= coef_a;
                                matrix_reg[{row, 2'd1}] <= coef_b;
                                matrix_reg[{row, 2'd2}] <= coef_c;
                                matrix_reg[{row, 2'd3}] <= coef_d;
                            end
                            MODE_FRAME:
                            begin
                                vtotal_reg  <= '0;
                                itotal_reg  <= '0;
                                cfirst_reg  <= '0;
                                cbase_reg   <= '0;
                                bic_reg     <= '0;
                                moffset_reg <= '0;
                                mverts_reg  <= '0;
                                bopen_reg   <= 1'b0;
                            end
                            MODE_VERTEX:
                            begin
                                step_reg  <= '0;
                                pvld_reg  <= 1'b0;
                                acc_reg   <= '0;
                                state_reg <= ST_MUL;
                            end
                            MODE_BEGIN, MODE_INDEX:
                                state_reg <= ST_EMIT;
                            default:
                                ;
                        endcase
                    end
                end

                // one product per cycle, accumulated in the following cycle
                ST_MUL:
                begin
                    if (pvld_reg)
                    begin
                        if (plast_reg)
                        begin
                            dot_reg[prow_reg] <= sum_next;
                            acc_reg           <= '0;
                        end
                        else
                            acc_reg <= sum_next;
                    end
                    if (!step_reg[4])
                    begin
                        prod_reg  <= prod_next;
                        prow_reg  <= step_reg[3:2];
                        plast_reg <= (step_reg[1:0] == 2'd3);
                        pvld_reg  <= 1'b1;
                        step_reg  <= step_reg + 5'd1;
                    end
                    else
                    begin
                        pvld_reg  <= 1'b0;
                        dsel_reg  <= '0;
                        state_reg <= ST_DIV_SET;
                    end
                end

                ST_DIV_SET:
                begin
                    if (wzero)
                        state_reg <= ST_EMIT;
                    else
                    begin
                        uw_reg    <= uw_next;
                        neg_reg   <= dnum[ACC_W-1] != dot_reg[3][ACC_W-1];
                        // integer part of the quotient needs more than 16 bits
                        ovf_reg   <= {16'd0, ua_next} >= {uw_next, 16'd0};
                        rem_reg   <= ACC_W'(ua_next[ACC_W-1:16]);
                        dvd_reg   <= {ua_next[15:0], 16'd0};
                        q_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV_RUN;
                    end
                end

                // restoring division, one quotient bit per cycle
                ST_DIV_RUN:
                begin
                    rem_reg <= ge ? ACC_W'(trial - {1'b0, uw_reg}) : trial[ACC_W-1:0];
                    q_reg   <= {q_reg[30:0], ge};
                    dvd_reg <= {dvd_reg[30:0], 1'b0};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                        state_reg <= ST_DIV_END;
                end

                ST_DIV_END:
                begin
                    res_reg[dsel_reg] <= sat_next;
                    if (dsel_reg == 2'd2)
                        state_reg <= ST_EMIT;
                    else
                    begin
                        dsel_reg  <= dsel_reg + 2'd1;
                        state_reg <= ST_DIV_SET;
                    end
                end

                ST_EMIT:
                begin
                    if (emit_go)
                    begin
                        out_valid_reg <= 1'b1;
                        ox_reg        <= '0;
                        oy_reg        <= '0;
                        oz_reg        <= '0;
                        oidx_reg      <= '0;
                        nb_reg        <= 1'b0;
                        bfirst_reg    <= '0;
                        bbase_reg     <= '0;
                        closed_reg    <= '0;
                        err_reg       <= ERR_NONE;
                        state_reg     <= ST_IDLE;
                        case (mode_reg)
                            MODE_VERTEX:
                            begin
                                kind_reg <= KIND_VERTEX;
                                if (!wzero)
                                begin
                                    ox_reg <= res_reg[0];
                                    oy_reg <= res_reg[1];
                                    oz_reg <= res_reg[2];
                                end
                                if (vtotal_reg >= MAX_C)
                                    err_reg <= ERR_FULL;
                                else
                                begin
                                    vtotal_reg <= vtotal_reg + CW'(1);
                                    if (wzero)
                                        err_reg <= ERR_WZERO;
                                end
                            end
                            MODE_INDEX:
                            begin
                                kind_reg <= KIND_INDEX;
                                if (vidx_reg >= mverts_reg)
                                    err_reg <= ERR_INDEX;
                                else if (itotal_reg >= MAX_C)
                                    err_reg <= ERR_FULL;
                                else
                                begin
                                    oidx_reg   <= vidx_reg + moffset_reg;
                                    itotal_reg <= itotal_reg + CW'(1);
                                    bic_reg    <= bic_reg + CW'(1);
                                end
                            end
                            default:
                            begin
                                // begin mesh: batch report
                                kind_reg <= KIND_BATCH;
                                if (toobig)
                                begin
                                    err_reg     <= ERR_FULL;
                                    mverts_reg  <= '0;
                                    moffset_reg <= '0;
                                    bfirst_reg  <= 21'(cfirst_reg);
                                    bbase_reg   <= 21'(cbase_reg);
                                end
                                else
                                begin
                                    if (open_new)
                                    begin
                                        nb_reg     <= 1'b1;
                                        closed_reg <= bopen_reg ? 21'(bic_reg) : 21'd0;
                                        cfirst_reg <= itotal_reg;
                                        cbase_reg  <= vtotal_reg;
                                        bic_reg    <= '0;
                                        bopen_reg  <= 1'b1;
                                        bfirst_reg <= 21'(itotal_reg);
                                    end
                                    else
                                        bfirst_reg <= 21'(cfirst_reg);
                                    bbase_reg   <= 21'(base_next);
                                    moffset_reg <= 16'(vtotal_reg - base_next);
                                    mverts_reg  <= mvc_reg;
                                end
                            end
                        endcase
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign out_x        = ox_reg;
    assign out_y        = oy_reg;
    assign out_z        = oz_reg;
    assign out_index    = oidx_reg;
    assign new_batch    = nb_reg;
    assign batch_first  = bfirst_reg;
    assign batch_base   = bbase_reg;
    assign closed_count = closed_reg;
    assign error        = err_reg;

    // Counters stay within the element limit
    assert property (@(posedge clk) disable iff (!rst_n)
        vtotal_reg <= MAX_C && itotal_reg <= MAX_C)
        else $error("element counter beyond limit");

    // With no batch open every batch position is cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        !bopen_reg |-> (cbase_reg == '0 && cfirst_reg == '0 && bic_reg == '0))
        else $error("batch state set with no open batch");

    // Batch base never passes the vertex count, batch count never passes the index count
    assert property (@(posedge clk) disable iff (!rst_n)
        cbase_reg <= vtotal_reg && bic_reg <= itotal_reg && cfirst_reg <= itotal_reg)
        else $error("batch position ahead of totals");

    // A result is only written when the output register is free or draining
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result dropped");

endmodule
